// ===== hw/rtl/dfrb_pkg.sv =====
// shared types and constants of the delimited frame ring buffer
package dfrb_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CfgIdxW = 1;

  localparam logic FUNC_PUSH = 1'b0;
  localparam logic FUNC_GET  = 1'b1;

  localparam logic [CfgIdxW-1:0] CFG_HEAD_BYTE = 1'b0;
  localparam logic [CfgIdxW-1:0] CFG_TAIL_BYTE = 1'b1;

  localparam logic [ByteW-1:0] HEAD_RESET = 8'd2;
  localparam logic [ByteW-1:0] TAIL_RESET = 8'd3;

  typedef enum logic [2:0] {
    ST_FRAME        = 3'd0,
    ST_PUSHED       = 3'd1,
    ST_FULL_KEPT    = 3'd2,
    ST_FULL_CLEARED = 3'd3,
    ST_EMPTY        = 3'd4,
    ST_NO_FRAME     = 3'd5
  } dfrb_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_FULL_RD,
    S_FULL_CHK,
    S_GET,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_OUT_RD,
    S_OUT_EMIT,
    S_REPORT
  } dfrb_state_e;

endpackage

// ===== hw/rtl/dfrb_store.sv =====
// byte store: one write port, one read port with registered read data
module dfrb_store import dfrb_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [ByteW-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [ByteW-1:0]         rdata_o
);

  logic [ByteW-1:0] mem_q [DEPTH];
  logic [ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/delimited_frame_ring_buffer.sv =====
// top level of the delimited frame ring buffer
//
// input channel (in_valid_i/in_ready_o): func_i = 0 pushes data_byte_i,
// func_i = 1 requests the next frame delimited by the head and tail bytes.
// output channel (out_valid_o/out_ready_i): one beat per push, one status
// beat for an empty store or no complete frame, or one beat per frame byte
// from head to tail; last_byte_o marks the final beat of each item.
// configuration: cfg_we_i writes cfg_data_i to head byte (index 0) or tail
// byte (index 1); the user must write only while the block is idle, as the block does not enforce it.
// flow: one item at a time; a new item is taken only back in S_IDLE. a push
// that finds room loads its beat into the output register from S_PUSH and
// returns to idle. a get dispatches in S_GET, then scans each stored byte
// through S_SCAN_RD and S_SCAN_CHK, since each step waits for the registered
// read of the byte memory, then sends each frame byte through S_OUT_RD and
// S_OUT_EMIT, or a status beat from S_REPORT. a push into a full store scans
// for a tail through S_FULL_RD and S_FULL_CHK, between S_PUSH and S_REPORT.
// reset: empty store, indices zero, head byte 2, tail byte 3; the memory
// itself is not cleared, only bytes inside the fill window are ever read.
// stall: a finished beat waits in the output register while the next item
// is accepted; work stops until that register can be loaded again.
module delimited_frame_ring_buffer import dfrb_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [ByteW-1:0]   data_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic [ByteW-1:0]   frame_byte_o,
  output logic               last_byte_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);
  localparam logic [CntW-1:0] CntOne  = CntW'(1);

  dfrb_state_e  state_q, state_d;
  dfrb_status_e code_q, code_d;
  logic [ByteW-1:0]  data_q;
  logic [ByteW-1:0]  head_q, tail_q;
  logic [IdxW-1:0]   rd_q, rd_d, wr_q, wr_d, p_q, p_d, t_q, t_d, h_q, h_d;
  logic [CntW-1:0]   fill_q, fill_d, rem_q, rem_d, trem_q, trem_d;
  logic              hv_q, hv_d;

  logic              out_valid_q;
  dfrb_status_e      out_status_q, out_status_n;
  logic [ByteW-1:0]  out_byte_q, out_byte_n;
  logic              out_last_q, out_last_n;
  logic              out_load, slot_free;

  logic              mem_we;
  logic [ByteW-1:0]  rdata;
  logic [IdxW-1:0]   p_inc, wr_inc;
  logic              in_fire;

  assign p_inc  = (p_q == IdxLast) ? '0 : p_q + 1'b1;
  assign wr_inc = (wr_q == IdxLast) ? '0 : wr_q + 1'b1;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  dfrb_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_q),
    .wdata_i (data_q),
    .raddr_i (p_q),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d      = state_q;
    code_d       = code_q;
    rd_d         = rd_q;
    wr_d         = wr_q;
    fill_d       = fill_q;
    p_d          = p_q;
    rem_d        = rem_q;
    t_d          = t_q;
    trem_d       = trem_q;
    h_d          = h_q;
    hv_d         = hv_q;
    mem_we       = 1'b0;
    out_load     = 1'b0;
    out_status_n = ST_FRAME;
    out_byte_n   = '0;
    out_last_n   = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d = (func_i == FUNC_GET) ? S_GET : S_PUSH;
        end
      end
      S_PUSH: begin
        if (fill_q == CntFull) begin
          p_d     = rd_q;
          rem_d   = fill_q;
          state_d = S_FULL_RD;
        end else if (slot_free) begin
          mem_we       = 1'b1;
          wr_d         = wr_inc;
          fill_d       = fill_q + 1'b1;
          out_load     = 1'b1;
          out_status_n = ST_PUSHED;
          state_d      = S_IDLE;
        end
      end
      S_FULL_RD: begin
        state_d = S_FULL_CHK;
      end
      S_FULL_CHK: begin
        if (rdata == tail_q) begin
          code_d  = ST_FULL_KEPT;
          state_d = S_REPORT;
        end else if (rem_q == CntOne) begin
          rd_d    = '0;
          wr_d    = '0;
          fill_d  = '0;
          code_d  = ST_FULL_CLEARED;
          state_d = S_REPORT;
        end else begin
          p_d     = p_inc;
          rem_d   = rem_q - 1'b1;
          state_d = S_FULL_RD;
        end
      end
      S_GET: begin
        if (fill_q == '0) begin
          code_d  = ST_EMPTY;
          state_d = S_REPORT;
        end else begin
          p_d     = rd_q;
          rem_d   = fill_q;
          hv_d    = 1'b0;
          state_d = S_SCAN_RD;
        end
      end
      S_SCAN_RD: begin
        state_d = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rdata == tail_q) begin
          if (hv_q) begin
            t_d     = p_q;
            trem_d  = rem_q;
            p_d     = h_q;
            state_d = S_OUT_RD;
          end else begin
            // tail with no head before it: drop through the tail, search again
            rd_d   = p_inc;
            fill_d = rem_q - 1'b1;
            if (rem_q == CntOne) begin
              code_d  = ST_EMPTY;
              state_d = S_REPORT;
            end else begin
              p_d     = p_inc;
              rem_d   = rem_q - 1'b1;
              state_d = S_SCAN_RD;
            end
          end
        end else begin
          if (rdata == head_q) begin
            hv_d = 1'b1;
            h_d  = p_q;
          end
          if (rem_q == CntOne) begin
            code_d  = ST_NO_FRAME;
            state_d = S_REPORT;
          end else begin
            p_d     = p_inc;
            rem_d   = rem_q - 1'b1;
            state_d = S_SCAN_RD;
          end
        end
      end
      S_OUT_RD: begin
        state_d = S_OUT_EMIT;
      end
      S_OUT_EMIT: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_status_n = ST_FRAME;
          out_byte_n   = rdata;
          out_last_n   = (p_q == t_q);
          if (p_q == t_q) begin
            rd_d    = p_inc;
            fill_d  = trem_q - 1'b1;
            state_d = S_IDLE;
          end else begin
            p_d     = p_inc;
            state_d = S_OUT_RD;
          end
        end
      end
      S_REPORT: begin
        if (slot_free) begin
          out_load     = 1'b1;
          out_status_n = code_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= '0;
      wr_q   <= '0;
      fill_q <= '0;
      head_q <= HEAD_RESET;
      tail_q <= TAIL_RESET;
    end else begin
      rd_q   <= rd_d;
      wr_q   <= wr_d;
      fill_q <= fill_d;
      if (cfg_we_i && cfg_idx_i == CFG_HEAD_BYTE) begin
        head_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_idx_i == CFG_TAIL_BYTE) begin
        tail_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    code_q <= code_d;
    p_q    <= p_d;
    rem_q  <= rem_d;
    t_q    <= t_d;
    trem_q <= trem_d;
    h_q    <= h_d;
    hv_q   <= hv_d;
    if (in_fire) begin
      data_q <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q <= out_status_n;
      out_byte_q   <= out_byte_n;
      out_last_q   <= out_last_n;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_status_q;
  assign frame_byte_o = out_byte_q;
  assign last_byte_o  = out_last_q;

endmodule

// ===== hw/rtl/dfrb_checker.sv =====
// port-level checks of the delimited frame ring buffer, bound to the top level
module dfrb_port_checks import dfrb_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_o,
  input logic             out_valid_o,
  input logic             out_ready_i,
  input logic [2:0]       status_o,
  input logic [ByteW-1:0] frame_byte_o,
  input logic             last_byte_o
);

  // a stalled output beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(frame_byte_o) && $stable(last_byte_o))
    else $error("stalled output beat changed");

  // only one item in flight: ready drops after an accepted beat
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // every status beat other than a frame byte ends its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_FRAME |-> last_byte_o)
    else $error("status beat without last marker");

  // status beats carry no byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_FRAME |-> frame_byte_o == '0)
    else $error("status beat with nonzero byte");

endmodule

bind delimited_frame_ring_buffer dfrb_port_checks u_dfrb_port_checks (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .frame_byte_o (frame_byte_o),
  .last_byte_o  (last_byte_o)
);

// ===== tb/sv/dfrb_checker.sv =====
// checker for the frame ring buffer: tracks store contents, predicts every beat and compares
`timescale 1ns / 1ps
module dfrb_checker import dfrb_pkg::*; #(
  parameter int unsigned DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ByteW-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic               func_i,
  input  logic [ByteW-1:0]   data_byte_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [2:0]         status_i,
  input  logic [ByteW-1:0]   frame_byte_i,
  input  logic               last_byte_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 beats_o,
  output int                 frames_o,
  output logic [5:0]         seen_o
);

  typedef struct packed {
    dfrb_status_e     status;
    logic [ByteW-1:0] fbyte;
    logic             last;
  } beat_t;

  beat_t            due_beats[$];
  logic [ByteW-1:0] ring [DEPTH];
  int unsigned      rd_pos;
  int unsigned      wr_pos;
  int unsigned      fill;
  logic [ByteW-1:0] head_val;
  logic [ByteW-1:0] tail_val;

  function automatic int unsigned wrap(int unsigned base, int unsigned off);
    return (base + off) % DEPTH;
  endfunction

  task automatic queue_beat(input dfrb_status_e st, input logic [ByteW-1:0] b, input logic l);
    beat_t e;
    e.status = st;
    e.fbyte  = b;
    e.last   = l;
    due_beats.push_back(e);
  endtask

  task automatic deframe_item(input logic fn, input logic [ByteW-1:0] val);
    int unsigned t;
    int unsigned h;
    int unsigned k;
    bit got_tail;
    bit got_head;
    bit done;
    bit has_tail;
    if (fn == FUNC_GET) begin
      done = 1'b0;
      while (!done) begin
        if (fill == 0) begin
          queue_beat(ST_EMPTY, '0, 1'b1);
          done = 1'b1;
        end else begin
          got_tail = 1'b0;
          t = 0;
          for (k = 0; k < fill && !got_tail; k++) begin
            if (ring[wrap(rd_pos, k)] == tail_val) begin
              t = k;
              got_tail = 1'b1;
            end
          end
          if (!got_tail) begin
            queue_beat(ST_NO_FRAME, '0, 1'b1);
            done = 1'b1;
          end else begin
            got_head = 1'b0;
            h = 0;
            for (k = t; k > 0 && !got_head; k--) begin
              if (ring[wrap(rd_pos, k - 1)] == head_val) begin
                h = k - 1;
                got_head = 1'b1;
              end
            end
            if (got_head) begin
              for (k = h; k <= t; k++) begin
                queue_beat(ST_FRAME, ring[wrap(rd_pos, k)], k == t);
              end
              done = 1'b1;
            end
            rd_pos = wrap(rd_pos, t + 1);
            fill   = fill - (t + 1);
          end
        end
      end
    end else if (fill >= DEPTH) begin
      has_tail = 1'b0;
      for (k = 0; k < fill; k++) begin
        if (ring[wrap(rd_pos, k)] == tail_val) has_tail = 1'b1;
      end
      if (!has_tail) begin
        rd_pos = 0;
        wr_pos = 0;
        fill   = 0;
        queue_beat(ST_FULL_CLEARED, '0, 1'b1);
      end else begin
        queue_beat(ST_FULL_KEPT, '0, 1'b1);
      end
    end else begin
      ring[wr_pos] = val;
      wr_pos = wrap(wr_pos, 1);
      fill++;
      queue_beat(ST_PUSHED, '0, 1'b1);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    beat_t due;
    if (!rst_ni) begin
      due_beats.delete();
      rd_pos       = 0;
      wr_pos       = 0;
      fill         = 0;
      head_val     = HEAD_RESET;
      tail_val     = TAIL_RESET;
      fail_count_o = 0;
      pending_o    = 0;
      beats_o      = 0;
      frames_o     = 0;
      seen_o       = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_HEAD_BYTE: head_val = cfg_data_i;
          CFG_TAIL_BYTE: tail_val = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) deframe_item(func_i, data_byte_i);
      if (out_valid_i && out_ready_i) begin
        beats_o++;
        if (status_i < 3'd6) seen_o[status_i] = 1'b1;
        if (status_i == ST_FRAME && last_byte_i) frames_o++;
        if (due_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none, got status %0d byte %02h last %0b",
                   $time, status_i, frame_byte_i, last_byte_i);
          fail_count_o++;
        end else begin
          due = due_beats.pop_front();
          if (status_i !== due.status) begin
            $display("%0t: status expected %0d got %0d", $time, due.status, status_i);
            fail_count_o++;
          end
          if (frame_byte_i !== due.fbyte) begin
            $display("%0t: frame byte expected %02h got %02h", $time, due.fbyte, frame_byte_i);
            fail_count_o++;
          end
          if (last_byte_i !== due.last) begin
            $display("%0t: last flag expected %0b got %0b", $time, due.last, last_byte_i);
            fail_count_o++;
          end
        end
      end
      pending_o = due_beats.size();
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// top of the frame ring buffer testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb;
  import dfrb_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx = '0;
  logic [ByteW-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_func = 1'b0;
  logic [ByteW-1:0]   in_data = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         status;
  logic [ByteW-1:0]   frame_byte;
  logic               last_byte;

  int                 fails;
  int                 pending;
  int                 beats;
  int                 frames;
  logic [5:0]         seen;

  int                 items = 0;
  bit                 calm = 1'b0;
  int                 stall_left = 0;
  logic [ByteW-1:0]   cur_head = HEAD_RESET;
  logic [ByteW-1:0]   cur_tail = TAIL_RESET;

  always #1 clk = ~clk;

  delimited_frame_ring_buffer dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .func_i      (in_func),
    .data_byte_i (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .status_o    (status),
    .frame_byte_o(frame_byte),
    .last_byte_o (last_byte)
  );

  dfrb_checker chk (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .func_i      (in_func),
    .data_byte_i (in_data),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .status_i    (status),
    .frame_byte_i(frame_byte),
    .last_byte_i (last_byte),
    .fail_count_o(fails),
    .pending_o   (pending),
    .beats_o     (beats),
    .frames_o    (frames),
    .seen_o      (seen)
  );

  always @(posedge clk) begin
    if (calm || !rst_n) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  function automatic logic [ByteW-1:0] plain_byte();
    logic [ByteW-1:0] b;
    b = ByteW'($urandom_range(0, 255));
    while (b == cur_head || b == cur_tail) b = ByteW'($urandom_range(0, 255));
    return b;
  endfunction

  task automatic send(input logic fn, input logic [ByteW-1:0] val);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func  <= fn;
    in_data  <= val;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    items++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_delims(input logic [ByteW-1:0] h, input logic [ByteW-1:0] t);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_HEAD_BYTE;
    cfg_data <= h;
    @(posedge clk);
    cfg_idx  <= CFG_TAIL_BYTE;
    cfg_data <= t;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_head = h;
    cur_tail = t;
  endtask

  // noise, head, payload, tail, get; all but head may be skipped; payload may be corrupt
  task automatic frame_seq();
    int noise;
    int len;
    noise = $urandom_range(0, 2);
    repeat (noise) send(FUNC_PUSH, ByteW'($urandom_range(0, 255)));
    send(FUNC_PUSH, cur_head);
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    repeat (len) begin
      send(FUNC_PUSH,
           ($urandom_range(0, 15) == 0) ? ByteW'($urandom_range(0, 255)) : plain_byte());
    end
    if ($urandom_range(0, 9) != 0) send(FUNC_PUSH, cur_tail);
    if ($urandom_range(0, 4) < 3) send(FUNC_GET, ByteW'($urandom_range(0, 255)));
  endtask

  task automatic random_mix(input int n);
    int start;
    int pick;
    int cnt;
    start = items;
    while (items - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        frame_seq();
      end else if (pick < 75) begin
        send(FUNC_GET, ByteW'($urandom_range(0, 255)));
      end else begin
        cnt = $urandom_range(1, 4);
        repeat (cnt) send(FUNC_PUSH, ByteW'($urandom_range(0, 255)));
      end
    end
  endtask

  // fill the store to overflow, with one full-length frame inside or with no tail at all
  task automatic fill_burst(input bit framed);
    repeat (4) send(FUNC_GET, ByteW'($urandom_range(0, 255)));
    if (framed) begin
      send(FUNC_PUSH, cur_head);
      repeat (62) send(FUNC_PUSH, plain_byte());
      send(FUNC_PUSH, cur_tail);
      repeat (2) send(FUNC_PUSH, plain_byte());
      send(FUNC_GET, ByteW'($urandom_range(0, 255)));
    end else begin
      repeat (66) send(FUNC_PUSH, plain_byte());
    end
  endtask

  initial begin
    logic [ByteW-1:0] rh;
    logic [ByteW-1:0] rt;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(FUNC_GET, 8'h00);
    send(FUNC_PUSH, 8'h00);
    send(FUNC_PUSH, 8'hFF);
    send(FUNC_GET, 8'hFF);
    send(FUNC_PUSH, HEAD_RESET);
    send(FUNC_PUSH, 8'hAA);
    send(FUNC_PUSH, TAIL_RESET);
    send(FUNC_GET, 8'h55);
    // tail with no head ahead of a good frame
    send(FUNC_PUSH, TAIL_RESET);
    send(FUNC_PUSH, HEAD_RESET);
    send(FUNC_PUSH, 8'h55);
    send(FUNC_PUSH, TAIL_RESET);
    send(FUNC_GET, 8'h00);
    send(FUNC_GET, 8'h00);
    send(FUNC_PUSH, TAIL_RESET);
    send(FUNC_GET, 8'h00);
    send(FUNC_PUSH, TAIL_RESET);
    send(FUNC_PUSH, 8'h07);
    send(FUNC_GET, 8'h00);
    send(FUNC_GET, 8'h00);
    random_mix(60);
    fill_burst(1'b0);
    settle();

    // head equal to tail
    set_delims(8'h7E, 8'h7E);
    send(FUNC_PUSH, 8'h7E);
    send(FUNC_PUSH, 8'h01);
    send(FUNC_PUSH, 8'h7E);
    send(FUNC_GET, 8'h00);
    send(FUNC_PUSH, 8'h05);
    send(FUNC_PUSH, 8'h7E);
    send(FUNC_PUSH, 8'h09);
    send(FUNC_GET, 8'h00);
    random_mix(30);
    settle();

    set_delims(8'h00, 8'hFF);
    fill_burst(1'b1);
    random_mix(50);
    settle();

    set_delims(8'hFF, 8'h00);
    random_mix(50);
    settle();

    rh = ByteW'($urandom_range(0, 255));
    rt = ByteW'($urandom_range(0, 255));
    while (rt == rh) rt = ByteW'($urandom_range(0, 255));
    set_delims(rh, rt);
    random_mix(40);
    calm = 1'b1;
    random_mix(35);
    settle();
    repeat (400) @(posedge clk);

    $display("sent %0d items under five delimiter settings, checked %0d beats in %0d frames",
             items, beats, frames);
    $display("status codes observed (bit per code): %b", seen);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout at %0t with %0d beats still due", $time, pending);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
